// File: sv/mso_pkg.sv
// Package for the multichannel square oscillator: types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mso_pkg;

  localparam int unsigned ChannelsDefault   = 4;
  localparam int unsigned SampleRateDefault = 40000;
  localparam logic [15:0] MaxFreqReset      = 16'd4000;
  localparam int unsigned QueueDepth        = 2;

  // Action codes.
  localparam logic [2:0] ActTick  = 3'd0;
  localparam logic [2:0] ActType  = 3'd1;
  localparam logic [2:0] ActEn    = 3'd2;
  localparam logic [2:0] ActFreq  = 3'd3;
  localparam logic [2:0] ActLevel = 3'd4;

  // Wave kinds.
  localparam logic [1:0] KindManual = 2'd0;
  localparam logic [1:0] KindSquare = 2'd1;
  localparam logic [1:0] KindNone   = 2'd3;

  // Status codes.
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBounds = 2'd1;
  localparam logic [1:0] StFreq   = 2'd2;
  localparam logic [1:0] StType   = 2'd3;

  localparam logic [31:0] TimeNone   = 32'hFFFF_FFFF;
  localparam logic [15:0] PeriodNone = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  channel_index;
    logic [15:0] argument;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  dac_channel;
    logic [7:0]  dac_level;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_REPLY,
    OP_FREQ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  action;
    logic [7:0]  channel_index;
    logic [15:0] argument;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: sv/mso_front.sv
// Front part: accepts requests, classifies them, and queues them for the back.
// Depends on mso_pkg.
`default_nettype none
module mso_front
  import mso_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  in_item_t       in_data,
  output logic           q_valid,
  input  wire logic      q_pop,
  output cmd_t           q_head
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t             mem [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW:0]    count;
  cmd_t             cls;
  logic             push;
  logic             pop;

  // Classify the incoming request; unknown actions are dropped by the push condition.
  always_comb begin
    cls.action        = in_data.action;
    cls.channel_index = in_data.channel_index;
    cls.argument      = in_data.argument;
    if (in_data.action == ActTick) begin
      cls.op = OP_TICK;
    end else if (in_data.action == ActFreq) begin
      cls.op = OP_FREQ;
    end else begin
      cls.op = OP_REPLY;
    end
  end

  assign in_stall = (count == (PtrW+1)'(QueueDepth));
  assign pop      = q_pop && (count != '0);
  assign push     = in_valid && !in_stall && (in_data.action <= ActLevel);
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// File: sv/mso_div.sv
// Restoring divider: quotient of a 16-bit constant over a 16-bit divisor.
// Depends on mso_pkg; one quotient bit a cycle, done holds until the next start.
`default_nettype none
module mso_div
  import mso_pkg::*;
#(
  parameter int unsigned SAMPLE_RATE = SampleRateDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial    = {rem, quo[15]} - {1'b0, dvs};
  assign quotient = quo;

  // One shift-subtract step a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= 5'd16;
        rem  <= '0;
        quo  <= 16'(SAMPLE_RATE);
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[14:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/mso_back.sv
// Back part: channel state, command execution and the tick scan.
// Depends on mso_pkg and mso_div.
`default_nettype none
module mso_back
  import mso_pkg::*;
#(
  parameter int unsigned CHANNELS    = ChannelsDefault,
  parameter int unsigned SAMPLE_RATE = SampleRateDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] max_frequency,
  input  wire logic        q_valid,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  output logic             idle
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t      state;
  state_t      state_next;
  logic [31:0] sample_counter;
  logic [1:0]  wave_kind      [CHANNELS];
  logic        channel_enabled[CHANNELS];
  logic [7:0]  manual_level   [CHANNELS];
  logic [15:0] square_period  [CHANNELS];
  logic [31:0] next_low_time  [CHANNELS];
  logic [31:0] next_high_time [CHANNELS];

  cmd_t        cur;
  logic [ChW-1:0] scan;
  logic [3:0]  scan_cnt;
  logic        pend_valid;
  out_item_t   pend;
  logic        div_start;
  logic        div_done;
  logic [15:0] quotient;

  logic        out_free;
  logic        in_range;
  logic [ChW-1:0] chi;
  logic [1:0]  status_c;
  logic        cmd_last_scan;
  logic        hit_low;
  logic        hit_high;
  logic        hit;
  logic        scan_go;
  logic        emit;
  out_item_t   emit_data;

  assign out_free = !out_valid || !out_stall;
  assign in_range = ({24'd0, q_head.channel_index} < 32'(CHANNELS));
  assign chi      = q_head.channel_index[ChW-1:0];
  assign idle     = (state == S_IDLE) && !q_valid && !out_valid && !pend_valid;

  mso_div #(.SAMPLE_RATE(SAMPLE_RATE)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (q_head.argument),
    .done     (div_done),
    .quotient (quotient)
  );

  // Status of a non-tick command at the queue head.
  always_comb begin
    status_c = StOk;
    if (!in_range) begin
      status_c = StBounds;
    end else begin
      unique case (q_head.action)
        ActType: begin
          if (q_head.argument > 16'(KindSquare)) begin
            status_c = StType;
          end else if ({14'd0, wave_kind[chi]} == q_head.argument) begin
            status_c = StType;
          end
        end
        ActFreq: begin
          if (q_head.argument == '0 || q_head.argument > max_frequency) begin
            status_c = StFreq;
          end else if (wave_kind[chi] != KindSquare) begin
            status_c = StType;
          end
        end
        ActLevel: begin
          if (wave_kind[chi] != KindManual) begin
            status_c = StType;
          end
        end
        default: status_c = StOk;
      endcase
    end
  end

  // Edge tests of the channel under scan.
  assign hit_low  = channel_enabled[scan] && (wave_kind[scan] == KindSquare) &&
                    (next_low_time[scan] <= sample_counter);
  assign hit_high = channel_enabled[scan] && (wave_kind[scan] == KindSquare) &&
                    (next_high_time[scan] <= sample_counter);
  assign hit = (channel_enabled[scan] && wave_kind[scan] == KindManual) ||
               hit_low || hit_high;
  assign cmd_last_scan = (scan_cnt == 4'(CHANNELS - 1));
  // The scan waits while a new hit finds a held write that cannot move to a full output register.
  assign scan_go = !(hit && pend_valid) || out_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          if (q_head.op == OP_TICK) begin
            state_next = S_SCAN;
          end else if (q_head.op == OP_FREQ && status_c == StOk) begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV:  if (div_done && out_free) state_next = S_IDLE;
      S_SCAN: if (cmd_last_scan && scan_go) state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = (state == S_IDLE) && q_valid && out_free;
    div_start = (state == S_IDLE) && q_valid && out_free &&
                q_head.op == OP_FREQ && status_c == StOk;
  end

  // Result loaded into the output register this cycle.
  always_comb begin
    emit      = 1'b0;
    emit_data = pend;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free && q_head.op != OP_TICK &&
            !(q_head.op == OP_FREQ && status_c == StOk)) begin
          emit      = 1'b1;
          emit_data = '{result_kind: 1'b0, dac_channel: '0, dac_level: '0,
                        status: status_c, last: 1'b1};
        end
      end
      S_DIV: begin
        if (div_done && out_free) begin
          emit      = 1'b1;
          emit_data = '{result_kind: 1'b0, dac_channel: '0, dac_level: '0,
                        status: StOk, last: 1'b1};
        end
      end
      S_SCAN: begin
        if (hit && pend_valid && out_free) begin
          emit = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free && pend_valid) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      if (emit) begin
        out_data <= emit_data;
      end
    end
  end

  // Datapath: channel state and held DAC write.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid     <= 1'b0;
      sample_counter <= '0;
      scan           <= '0;
      scan_cnt       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        wave_kind[i]       <= KindNone;
        channel_enabled[i] <= 1'b0;
        manual_level[i]    <= '0;
        square_period[i]   <= PeriodNone;
        next_low_time[i]   <= TimeNone;
        next_high_time[i]  <= TimeNone;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid && out_free) begin
            cur <= q_head;
            if (q_head.op == OP_TICK) begin
              sample_counter <= sample_counter + 1'b1;
              scan           <= '0;
              scan_cnt       <= '0;
              pend_valid     <= 1'b0;
            end else if (!(q_head.op == OP_FREQ && status_c == StOk)) begin
              if (status_c == StOk) begin
                unique case (q_head.action)
                  ActType: begin
                    channel_enabled[chi] <= 1'b0;
                    wave_kind[chi]       <= q_head.argument[1:0];
                    if (q_head.argument[1:0] == KindManual) begin
                      manual_level[chi] <= '0;
                    end else begin
                      square_period[chi]  <= PeriodNone;
                      next_low_time[chi]  <= TimeNone;
                      next_high_time[chi] <= TimeNone;
                    end
                  end
                  ActEn:    channel_enabled[chi] <= (q_head.argument != '0);
                  ActLevel: manual_level[chi]    <= q_head.argument[7:0];
                  default:  ;
                endcase
              end
            end
          end
        end
        S_DIV: begin
          if (div_done && out_free) begin
            square_period[cur.channel_index[ChW-1:0]]  <= quotient;
            next_low_time[cur.channel_index[ChW-1:0]]  <=
              sample_counter + {17'd0, quotient[15:1]};
            next_high_time[cur.channel_index[ChW-1:0]] <=
              sample_counter + {16'd0, quotient};
          end
        end
        S_SCAN: begin
          // One channel a cycle while scan_go holds; a write is held until the next is known.
          if (scan_go) begin
            if (hit) begin
              if (hit_low) begin
                next_low_time[scan] <= next_low_time[scan] + {16'd0, square_period[scan]};
              end else if (hit_high) begin
                next_high_time[scan] <= next_high_time[scan] +
                                        {16'd0, square_period[scan]};
              end
              pend_valid <= 1'b1;
              pend <= '{result_kind: 1'b1, dac_channel: 3'(scan),
                        dac_level: (wave_kind[scan] == KindManual) ? manual_level[scan] :
                                   (hit_low ? 8'h00 : 8'hFF),
                        status: StOk, last: 1'b0};
            end
            scan     <= scan + 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/multichannel_square_oscillator_unit.sv
// Top level of the multichannel square oscillator: front, queue, back, config.
// Depends on mso_pkg, mso_front and mso_back.
//
//  Channel  | Signals                      | Direction | Moves
//  in       | in_valid, in_stall, in_data  | into      | one request
//  out      | out_valid, out_stall, out_data | out of  | one result
//  cfg      | cfg_valid, cfg_ready, cfg_data | into    | max_frequency
//
// A frequency command runs the 16-step divider before its reply.
// A tick scan visits one channel per cycle except while the output stalls it.
// Reset (rst, synchronous) clears all channel state at once; no clearing pass.
// A stalled output holds the back; the two-entry queue keeps the front going.
`default_nettype none
module multichannel_square_oscillator_unit
  import mso_pkg::*;
#(
  parameter int unsigned CHANNELS    = ChannelsDefault,
  parameter int unsigned SAMPLE_RATE = SampleRateDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic        q_valid;
  logic        q_pop;
  cmd_t        q_head;
  logic [15:0] max_frequency;
  logic        idle;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frequency <= MaxFreqReset;
    end else if (cfg_valid && cfg_ready) begin
      max_frequency <= cfg_data;
    end
  end

  mso_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  mso_back #(.CHANNELS(CHANNELS), .SAMPLE_RATE(SAMPLE_RATE)) u_back (
    .clk           (clk),
    .rst           (rst),
    .max_frequency (max_frequency),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .idle          (idle)
  );

`ifndef ASSERT_OFF
  // A status reply always closes its request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_kind |-> out_data.last)
    else $error("status reply without last");
  // DAC writes name an existing channel.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind |-> 32'(out_data.dac_channel) < CHANNELS)
    else $error("DAC write to missing channel");
  // An idle block holds no result.
  assert property (@(posedge clk) disable iff (rst)
    idle |-> !out_valid)
    else $error("idle with pending result");
`endif

endmodule
`default_nettype wire

// File: tb/multichannel_square_oscillator_unit_tb.sv
// Testbench for the multichannel square oscillator: directed and random requests,
// checked against a behavioral predictor. Depends on mso_pkg and the top level.
`default_nettype none
module multichannel_square_oscillator_unit_tb;
  import mso_pkg::*;

  localparam int NumCh = 4;
  localparam int unsigned SampleRate = 40000;
  localparam int CycleLimit = 400000;
  localparam int LatencyDrain = 60;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  multichannel_square_oscillator_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state mirrors the oscillator bank.
  logic [15:0] freq_limit;
  logic [31:0] sample_count;
  logic [1:0]  kind_of [NumCh];
  logic        enabled_of [NumCh];
  logic [7:0]  level_of [NumCh];
  logic [15:0] period_of [NumCh];
  logic [31:0] low_due [NumCh];
  logic [31:0] high_due [NumCh];

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  int mismatches;
  int cycles;
  int accepted;
  bit hold_output;
  bit drain_pause;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t status_reply(logic [1:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Compute the results of one accepted request and update the predictor.
  task automatic predict_request(in_item_t req);
    int ch;
    int n;
    logic [1:0] st;
    logic [31:0] p;
    out_item_t r;
    ch = req.channel_index;
    st = StOk;
    case (req.action)
      ActTick: begin
        sample_count = sample_count + 1;
        n = 0;
        for (int i = 0; i < NumCh; i++) begin
          r = '0;
          r.result_kind = 1'b1;
          r.dac_channel = i[2:0];
          if (!enabled_of[i] || kind_of[i] == KindNone) continue;
          if (kind_of[i] == KindManual) begin
            r.dac_level = level_of[i];
          end else if (kind_of[i] == KindSquare) begin
            if (low_due[i] <= sample_count) begin
              low_due[i] = low_due[i] + period_of[i];
              r.dac_level = 8'h00;
            end else if (high_due[i] <= sample_count) begin
              high_due[i] = high_due[i] + period_of[i];
              r.dac_level = 8'hFF;
            end else begin
              continue;
            end
          end else begin
            continue;
          end
          expected_results.push_back(r);
          n++;
        end
        if (n > 0) expected_results[$].last = 1'b1;
        return;
      end
      ActType: begin
        if (ch >= NumCh) st = StBounds;
        else if (req.argument > KindSquare) st = StType;
        else if ({14'd0, kind_of[ch]} == req.argument) st = StType;
        else begin
          enabled_of[ch] = 1'b0;
          kind_of[ch] = req.argument[1:0];
          if (req.argument[1:0] == KindManual) begin
            level_of[ch] = 8'h00;
          end else begin
            period_of[ch] = PeriodNone;
            low_due[ch] = TimeNone;
            high_due[ch] = TimeNone;
          end
        end
      end
      ActEn: begin
        if (ch >= NumCh) st = StBounds;
        else enabled_of[ch] = (req.argument != 0);
      end
      ActFreq: begin
        if (ch >= NumCh) st = StBounds;
        else if (req.argument == 0 || req.argument > freq_limit) st = StFreq;
        else if (kind_of[ch] != KindSquare) st = StType;
        else begin
          p = SampleRate / req.argument;
          period_of[ch] = p[15:0];
          low_due[ch] = sample_count + (period_of[ch] >> 1);
          high_due[ch] = sample_count + period_of[ch];
        end
      end
      ActLevel: begin
        if (ch >= NumCh) st = StBounds;
        else if (kind_of[ch] != KindManual) st = StType;
        else level_of[ch] = req.argument[7:0];
      end
      default: return;
    endcase
    expected_results.push_back(status_reply(st));
  endtask

  // Sender: offers queued requests with random gaps.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predict_request(in_data);
      accepted <= accepted + 1;
      if (send_gap == 0 && !drain_pause && pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        send_gap <= $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (!drain_pause && pending_requests.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
        send_gap <= $urandom_range(0, 4);
      end
    end
  end

  // Receiver: random stalls, a long hold-off on request, and checking.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else if (out_data !== expected_results[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("expected %p actual %p", expected_results[0], out_data);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (hold_output) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        stall_left <= $urandom_range(0, 4);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("multichannel_square_oscillator_unit: mismatch");
      $finish;
    end
  end

  function automatic in_item_t make_request(logic [2:0] act, logic [7:0] ch,
                                            logic [15:0] arg);
    in_item_t r;
    r.action = act;
    r.channel_index = ch;
    r.argument = arg;
    return r;
  endfunction

  // Wait until every queued request is accepted and every result has come.
  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LatencyDrain) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    freq_limit = val;
  endtask

  // Random mix: mostly valid setup and ticks, some noise on the fields.
  task automatic queue_random(int count);
    logic [2:0] act;
    logic [7:0] ch;
    logic [15:0] arg;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NumCh - 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          act = ActTick;
          arg = 16'($urandom);
        end
        9, 10: begin
          act = ActType;
          arg = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
        end
        11, 12: begin
          act = ActEn;
          arg = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
        end
        13, 14, 15: begin
          act = ActFreq;
          arg = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                16'($urandom_range(2000, 4000));
        end
        16, 17: begin
          act = ActLevel;
          arg = 16'($urandom);
        end
        default: begin
          act = 3'($urandom_range(5, 7));
          arg = 16'($urandom);
        end
      endcase
      pending_requests.push_back(make_request(act, ch, arg));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    accepted = 0;
    hold_output = 1'b0;
    drain_pause = 1'b0;
    freq_limit = MaxFreqReset;
    sample_count = '0;
    for (int i = 0; i < NumCh; i++) begin
      kind_of[i] = KindNone;
      enabled_of[i] = 1'b0;
      level_of[i] = '0;
      period_of[i] = PeriodNone;
      low_due[i] = TimeNone;
      high_due[i] = TimeNone;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: bounds, type rejections, frequency extremes, levels, ticks.
    pending_requests.push_back(make_request(ActTick, 8'd0, 16'd0));
    pending_requests.push_back(make_request(ActType, 8'd255, 16'd0));
    pending_requests.push_back(make_request(ActType, 8'd0, 16'd2));
    pending_requests.push_back(make_request(ActType, 8'd0, 16'hFFFF));
    pending_requests.push_back(make_request(ActType, 8'd0, 16'd0));
    pending_requests.push_back(make_request(ActType, 8'd0, 16'd0));
    pending_requests.push_back(make_request(ActLevel, 8'd0, 16'hFFAA));
    pending_requests.push_back(make_request(ActEn, 8'd0, 16'h8000));
    pending_requests.push_back(make_request(ActType, 8'd1, 16'd1));
    pending_requests.push_back(make_request(ActFreq, 8'd1, 16'd0));
    pending_requests.push_back(make_request(ActFreq, 8'd1, 16'd4001));
    pending_requests.push_back(make_request(ActFreq, 8'd0, 16'd100));
    pending_requests.push_back(make_request(ActFreq, 8'd4, 16'd100));
    pending_requests.push_back(make_request(ActLevel, 8'd1, 16'd5));
    pending_requests.push_back(make_request(ActFreq, 8'd1, 16'd4000));
    pending_requests.push_back(make_request(ActEn, 8'd1, 16'd1));
    pending_requests.push_back(make_request(ActEn, 8'd200, 16'd1));
    for (int i = 0; i < 6; i++)
      pending_requests.push_back(make_request(ActTick, 8'hFF, 16'hFFFF));
    pending_requests.push_back(make_request(3'd7, 8'hFF, 16'hFFFF));
    pending_requests.push_back(make_request(ActEn, 8'd0, 16'd0));
    wait_idle();

    // Long receiver hold-off while the sender keeps offering.
    write_limit(16'd65535);
    queue_random(60);
    hold_output = 1'b1;
    repeat (200) @(posedge clk);
    hold_output = 1'b0;
    wait_idle();

    // Lowest limit.
    write_limit(16'd1);
    pending_requests.push_back(make_request(ActFreq, 8'd1, 16'd1));
    pending_requests.push_back(make_request(ActFreq, 8'd1, 16'd2));
    queue_random(80);
    wait_idle();

    // Back to a mid setting, then the bulk with a sender pause midway.
    write_limit(16'd4000);
    queue_random(130);
    while (pending_requests.size() > 60) @(posedge clk);
    drain_pause = 1'b1;
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    drain_pause = 1'b0;
    wait_idle();
    write_limit(16'($urandom_range(1000, 40000)));
    queue_random(170);
    wait_idle();

    if (mismatches == 0)
      $display("multichannel_square_oscillator_unit: match");
    else
      $display("multichannel_square_oscillator_unit: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
